>>> src/wcc_pkg.sv
// Shared constants and types for the water column colour pipeline.
package wcc_pkg;

  // Channel and thickness formats.
  localparam int CHAN_BITS  = 16;
  localparam int THICK_BITS = 16;
  localparam int THICK_MAG  = THICK_BITS - 1;

  // Coefficient and colour fields inside each 48-bit register.
  localparam int FIELD_BITS = 16;
  localparam int NUM_CHAN   = 3;
  localparam int REG_BITS   = FIELD_BITS * NUM_CHAN;
  localparam int EXT_BITS   = FIELD_BITS + 1;

  // Optical depth: Q.12 extinction times Q.8 thickness gives Q.20.
  localparam int DEPTH_FRAC = 20;
  localparam int DEPTH_BITS = EXT_BITS + THICK_MAG;
  localparam int WHOLE_BITS = 4;

  // Transmittance and albedo are Q0.16 values from 0 to 65536.
  localparam int Q16_BITS = 17;

  // Exponential unit: Taylor terms, whole-metre steps and latency.
  localparam int TAYLOR_TERMS = 13;
  localparam int WHOLE_MAX    = 15;
  localparam int EXP_LAT      = 1 + 3 * (TAYLOR_TERMS - 1) + WHOLE_MAX + 1;
  localparam logic [30:0] EXP_M1_Q32 = 31'd1580030169;

  // Albedo divider: one quotient bit per step, four steps per stage.
  localparam int DIV_STEPS = Q16_BITS;
  localparam int DIV_PER   = 4;
  localparam int DIV_REGS  = (DIV_STEPS + DIV_PER - 1) / DIV_PER;

  // Lane latency: depth stage, exponential, then three combine stages.
  localparam int LANE_LAT = 1 + EXP_LAT + 3;

  // Final sum is Q.48; rounding drops down to the channel fraction.
  localparam int SUM_BITS = 51;
  localparam int ATT_SHIFT = 32 - CHAN_BITS;
  localparam int RND_SHIFT = 48 - CHAN_BITS;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ABSORPTION = 2'd0,
    REG_SCATTERING = 2'd1,
    REG_COLOUR     = 2'd2
  } reg_index_t;

  // Running state of the Taylor series for exp(-y).
  typedef struct packed {
    logic                  cut;
    logic [WHOLE_BITS-1:0] whole;
    logic [31:0]           y;
    logic [31:0]           term;
    logic [32:0]           sum;
  } tay_t;

  // Partial state of the albedo divider.
  typedef struct packed {
    logic [EXT_BITS:0]   rem;
    logic [Q16_BITS-1:0] quo;
    logic [EXT_BITS-1:0] ext;
    logic                zero;
  } div_t;

  // Per-lane side data that travels next to the exponential unit.
  typedef struct packed {
    logic [CHAN_BITS-1:0]  bg;
    logic [FIELD_BITS-1:0] col;
  } side_t;

endpackage

>>> src/wcc_exp.sv
// Pipelined exp(-d) for a Q.20 optical depth, giving Q0.16 transmittance.
module wcc_exp import wcc_pkg::*; (
  input  logic                  clk,
  input  logic                  adv,
  input  logic [DEPTH_BITS-1:0] depth,
  output logic [Q16_BITS-1:0]   trans
);

  tay_t tay [0:TAYLOR_TERMS-1];
  logic [32:0]           wt    [0:WHOLE_MAX];
  logic                  wcut  [0:WHOLE_MAX];
  logic [WHOLE_BITS-1:0] wwh   [0:WHOLE_MAX];

  // First term of the series is y itself.
  always_ff @(posedge clk) begin
    if (adv) begin
      tay[0].cut   <= |depth[DEPTH_BITS-1:DEPTH_FRAC+WHOLE_BITS];
      tay[0].whole <= depth[DEPTH_FRAC+WHOLE_BITS-1:DEPTH_FRAC];
      tay[0].y     <= {depth[DEPTH_FRAC-1:0], 12'd0};
      tay[0].term  <= {depth[DEPTH_FRAC-1:0], 12'd0};
      tay[0].sum   <= 33'h1_0000_0000 - {1'b0, depth[DEPTH_FRAC-1:0], 12'd0};
    end
  end

  // Each later term: multiply by y, then divide by n through a reciprocal.
  for (genvar k = 0; k < TAYLOR_TERMS - 1; k++) begin : g_term
    localparam int N = k + 2;
    localparam logic [34:0] RECIP = 35'((36'd1 << 35) / N);
    tay_t        a_st;
    tay_t        b_st;
    logic [31:0] a_prod;
    logic [31:0] b_prod;
    logic [31:0] b_q;
    logic [63:0] a_full;
    logic [66:0] b_full;
    logic [31:0] rem;
    logic [31:0] term;

    assign a_full = 64'(tay[k].term) * 64'(tay[k].y);
    assign b_full = 67'(a_prod) * 67'(RECIP);

    always_ff @(posedge clk) begin
      if (adv) begin
        a_st   <= tay[k];
        a_prod <= a_full[63:32];
        b_st   <= a_st;
        b_prod <= a_prod;
        b_q    <= 32'(b_full >> 35);
      end
    end

    // The reciprocal estimate may be one short; one compare fixes it.
    always_comb begin
      rem  = b_prod - b_q * 32'(N);
      term = b_q + ((rem >= 32'(N)) ? 32'd1 : 32'd0);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tay[k+1].cut   <= b_st.cut;
        tay[k+1].whole <= b_st.whole;
        tay[k+1].y     <= b_st.y;
        tay[k+1].term  <= term;
        tay[k+1].sum   <= (N % 2 == 1) ? b_st.sum - {1'b0, term} : b_st.sum + {1'b0, term};
      end
    end
  end

  assign wt[0]   = tay[TAYLOR_TERMS-1].sum;
  assign wcut[0] = tay[TAYLOR_TERMS-1].cut;
  assign wwh[0]  = tay[TAYLOR_TERMS-1].whole;

  // One rounded multiply by exp(-1) per whole metre of depth.
  for (genvar i = 0; i < WHOLE_MAX; i++) begin : g_whole
    logic [63:0] prod;
    assign prod = 64'(wt[i]) * 64'(EXP_M1_Q32) + 64'h8000_0000;
    always_ff @(posedge clk) begin
      if (adv) begin
        wt[i+1]   <= (WHOLE_BITS'(i) < wwh[i]) ? 33'(prod >> 32) : wt[i];
        wcut[i+1] <= wcut[i];
        wwh[i+1]  <= wwh[i];
      end
    end
  end

  // Round to Q0.16; depths of 16 or more give zero.
  always_ff @(posedge clk) begin
    if (adv) begin
      trans <= wcut[WHOLE_MAX] ? '0 : Q16_BITS'((wt[WHOLE_MAX] + 33'h8000) >> 16);
    end
  end

endmodule

>>> src/wcc_albedo.sv
// Pipelined albedo divider, scattering * 2^16 / extinction, timed to match exp.
module wcc_albedo import wcc_pkg::*; (
  input  logic                  clk,
  input  logic                  adv,
  input  logic [EXT_BITS-1:0]   ext,
  input  logic [FIELD_BITS-1:0] sc,
  output logic [Q16_BITS-1:0]   albedo
);

  localparam int ALB_DLY = EXP_LAT - DIV_REGS;

  div_t dv [0:DIV_REGS];
  logic [Q16_BITS-1:0] dly [0:ALB_DLY];

  assign dv[0] = '{rem: (EXT_BITS+1)'(sc), quo: '0, ext: ext, zero: (ext == '0)};

  // Restoring division, a few quotient bits per stage.
  for (genvar s = 0; s < DIV_REGS; s++) begin : g_div
    div_t nx;
    always_comb begin
      nx = dv[s];
      for (int j = 0; j < DIV_PER; j++) begin
        if (s * DIV_PER + j < DIV_STEPS) begin
          if (s * DIV_PER + j != 0) begin
            nx.rem = nx.rem << 1;
            nx.quo = nx.quo << 1;
          end
          if (nx.rem >= {1'b0, nx.ext}) begin
            nx.rem    = nx.rem - {1'b0, nx.ext};
            nx.quo[0] = 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv[s+1] <= nx;
      end
    end
  end

  // Zero extinction gives zero albedo.
  assign dly[0] = dv[DIV_REGS].zero ? '0 : dv[DIV_REGS].quo;

  for (genvar d = 0; d < ALB_DLY; d++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        dly[d+1] <= dly[d];
      end
    end
  end

  assign albedo = dly[ALB_DLY];

endmodule

>>> src/wcc_lane.sv
// One colour channel: optical depth, transmittance, albedo and final blend.
module wcc_lane import wcc_pkg::*; (
  input  logic                  clk,
  input  logic                  adv,
  input  logic [THICK_MAG-1:0]  thick,
  input  logic [CHAN_BITS-1:0]  bg,
  input  logic [FIELD_BITS-1:0] absorb,
  input  logic [FIELD_BITS-1:0] scatter,
  input  logic [FIELD_BITS-1:0] colour,
  output logic [CHAN_BITS-1:0]  shaded
);

  logic [DEPTH_BITS-1:0] depth;
  logic [EXT_BITS-1:0]   ext_q;
  logic [FIELD_BITS-1:0] sc_q;
  logic [EXT_BITS-1:0]   ext;
  logic [Q16_BITS-1:0]   trans;
  logic [Q16_BITS-1:0]   albedo;
  side_t                 side [0:EXP_LAT];

  logic [2*Q16_BITS-1:0]           p1;
  logic [Q16_BITS+CHAN_BITS-1:0]   att1;
  logic [FIELD_BITS-1:0]           col1;
  logic [SUM_BITS-1:0]             insc;
  logic [SUM_BITS-1:0]             att2;
  logic [SUM_BITS-1:0]             sum;
  logic [SUM_BITS-RND_SHIFT-1:0]   res;

  assign ext = EXT_BITS'(absorb) + EXT_BITS'(scatter);

  // Optical depth stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      depth   <= DEPTH_BITS'(ext) * DEPTH_BITS'(thick);
      ext_q   <= ext;
      sc_q    <= scatter;
      side[0] <= '{bg: bg, col: colour};
    end
  end

  wcc_exp u_exp (
    .clk   (clk),
    .adv   (adv),
    .depth (depth),
    .trans (trans)
  );

  wcc_albedo u_albedo (
    .clk    (clk),
    .adv    (adv),
    .ext    (ext_q),
    .sc     (sc_q),
    .albedo (albedo)
  );

  // Background and colour ride alongside the exponential.
  for (genvar d = 0; d < EXP_LAT; d++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        side[d+1] <= side[d];
      end
    end
  end

  // Blend: T * background plus (1 - T) * albedo * colour, rounded and saturated.
  assign sum = att2 + insc;
  assign res = (SUM_BITS-RND_SHIFT)'((sum + (SUM_BITS'(1) << (RND_SHIFT - 1))) >> RND_SHIFT);

  always_ff @(posedge clk) begin
    if (adv) begin
      p1     <= (2*Q16_BITS)'(Q16_BITS'(65536) - trans) * (2*Q16_BITS)'(albedo);
      att1   <= (Q16_BITS+CHAN_BITS)'(trans) * (Q16_BITS+CHAN_BITS)'(side[EXP_LAT].bg);
      col1   <= side[EXP_LAT].col;
      insc   <= SUM_BITS'(p1) * SUM_BITS'(col1);
      att2   <= SUM_BITS'(att1) << ATT_SHIFT;
      shaded <= (|res[SUM_BITS-RND_SHIFT-1:CHAN_BITS]) ? '1 : res[CHAN_BITS-1:0];
    end
  end

endmodule

>>> src/water_column_colour_top.sv
// Top level of the water column colour block: registers, lanes and stream control.
// Throughput: one pixel per cycle; the three channel lanes run side by side and
// the pipeline holds whenever the output register is full and not taken.
// Reset (rst, synchronous): clears all valid flags and the three coefficient
// registers to zero; pipeline data registers are not reset.
module water_column_colour_top import wcc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // s_tdata: thickness, background_red, background_green, background_blue
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [63:0]         s_tdata,
  // m_tdata: shaded_red, shaded_green, shaded_blue
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [47:0]         m_tdata,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [REG_BITS-1:0] cfg_data
);

  logic [REG_BITS-1:0]  absorption_rgb;
  logic [REG_BITS-1:0]  scattering_rgb;
  logic [REG_BITS-1:0]  scatter_colour_rgb;
  logic [LANE_LAT:1]    vld;
  logic                 adv;
  logic [THICK_MAG-1:0] thick;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      absorption_rgb     <= '0;
      scattering_rgb     <= '0;
      scatter_colour_rgb <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ABSORPTION: absorption_rgb     <= cfg_data;
        REG_SCATTERING: scattering_rgb     <= cfg_data;
        REG_COLOUR:     scatter_colour_rgb <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless a finished result is waiting.
  assign adv      = !vld[LANE_LAT] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LANE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LANE_LAT-1:1], s_tvalid};
    end
  end

  // Negative thickness counts as zero.
  assign thick = s_tdata[THICK_BITS-1] ? '0 : s_tdata[THICK_MAG-1:0];

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    wcc_lane u_lane (
      .clk     (clk),
      .adv     (adv),
      .thick   (thick),
      .bg      (s_tdata[THICK_BITS + c*CHAN_BITS +: CHAN_BITS]),
      .absorb  (absorption_rgb[c*FIELD_BITS +: FIELD_BITS]),
      .scatter (scattering_rgb[c*FIELD_BITS +: FIELD_BITS]),
      .colour  (scatter_colour_rgb[c*FIELD_BITS +: FIELD_BITS]),
      .shaded  (m_tdata[c*CHAN_BITS +: CHAN_BITS])
    );
  end

endmodule

>>> src/wcc_checker.sv
// Port-level checks on the water column colour top level, bound to it.
module wcc_checker import wcc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // No result is presented right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // An empty output register never blocks input requests.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // A stalled result stops the input side.
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

endmodule

bind water_column_colour_top wcc_checker u_wcc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
